[src/bus_capture_packet_framer_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bus capture packet framer
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BUS_CAPTURE_PACKET_FRAMER_TOP_ASSERT_SVH
`define BUS_CAPTURE_PACKET_FRAMER_TOP_ASSERT_SVH

// Implication checked outside reset.
`define BCPF_ASSERT_RUN(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define BCPF_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/bcpf_pkg.sv]
// ----------------------------------------------------------------------------
// Bus capture packet framer package
// Widths, packet constants and register map shared by the framer files.
// ----------------------------------------------------------------------------
package bcpf_pkg;

  localparam int NUM_SOURCES_DEF = 2;

  localparam int CAPTURE_W = 29;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  localparam int PKT_BYTES  = 12;
  localparam int PKT_W      = PKT_BYTES * 8;
  localparam int BYTE_IDX_W = $clog2(PKT_BYTES);
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(PKT_BYTES - 1);

  localparam logic [7:0]  SYNC0       = 8'hAA;
  localparam logic [7:0]  SYNC1       = 8'h55;
  localparam logic [7:0]  TYPE_STATUS = 8'h01;
  localparam logic [7:0]  TYPE_EVENT  = 8'h02;
  localparam logic [15:0] PEND_MAX    = 16'hFFFF;

  localparam logic FUNC_EVENT  = 1'b0;
  localparam logic FUNC_STATUS = 1'b1;

  // Register select is address bit 2 (4-byte spacing).
  localparam int   REG_SEL_BIT    = 2;
  localparam logic REG_ARMED      = 1'b0;
  localparam logic REG_DROP_THRESH = 1'b1;

  localparam logic [DATA_W-1:0] DROP_THRESH_RESET = 32'd8192;

endpackage

[src/bcpf_if.sv]
// ----------------------------------------------------------------------------
// Framer channel interfaces
// Valid/ready channels for capture items and packet bytes.
// ----------------------------------------------------------------------------
interface bcpf_item_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic                         source_id;
  logic [bcpf_pkg::CAPTURE_W-1:0] capture_word;
  logic [31:0]                  timestamp_us;
  logic [31:0]                  pending_count;

  modport source (
    output valid, func, source_id, capture_word, timestamp_us, pending_count,
    input  ready
  );
  modport sink (
    input  valid, func, source_id, capture_word, timestamp_us, pending_count,
    output ready
  );
endinterface

interface bcpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

[src/bus_capture_packet_framer_top.sv]
// ----------------------------------------------------------------------------
// Bus capture packet framer, top level
// An accepted event item, or status item while armed, goes to the packet holding
// register, then to the byte serializer: 12 bytes per packet, one byte per cycle
// while result.ready is high; a second item waits in the packet holding register.
// Reset clears pipeline state, drop state, armed and sets threshold to 8192.
// ----------------------------------------------------------------------------
module bus_capture_packet_framer_top #(
  parameter int NUM_SOURCES = bcpf_pkg::NUM_SOURCES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  bcpf_item_if.sink                     item,
  bcpf_byte_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcpf_pkg::PADDR_W-1:0]  paddr,
  input  logic [bcpf_pkg::DATA_W-1:0]   pwdata,
  output logic [bcpf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bcpf_pkg::*;

  logic                  armed;
  logic [DATA_W-1:0]     drop_threshold;
  logic                  cfg_write;

  logic                  drop_flag  [NUM_SOURCES];
  logic [7:0]            drop_count [NUM_SOURCES];

  logic [PKT_W-1:0]      hold_data;
  logic                  hold_valid;
  logic [PKT_W-1:0]      shift_data;
  logic                  shift_valid;
  logic [BYTE_IDX_W-1:0] byte_idx;

  logic                  item_fire;
  logic                  out_fire;
  logic                  shift_free;
  logic                  load;
  logic                  is_status;
  logic                  emits;
  logic                  over;
  logic                  sel_flag;
  logic [7:0]            sel_count;
  logic                  rep_flag;
  logic [7:0]            rep_count;
  logic [15:0]           pend_sat;
  logic [PKT_W-1:0]      pkt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      drop_threshold <= DROP_THRESH_RESET;
    end else if (cfg_write) begin
      case (paddr[REG_SEL_BIT])
        REG_ARMED:       armed <= pwdata[0];
        REG_DROP_THRESH: drop_threshold <= pwdata;
        default:         armed <= armed;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_ARMED:       prdata = {{(DATA_W-1){1'b0}}, armed};
      REG_DROP_THRESH: prdata = drop_threshold;
      default:         prdata = '0;
    endcase
  end

  assign out_fire   = result.valid && result.ready;
  assign shift_free = !shift_valid || (out_fire && byte_idx == LAST_IDX);
  assign load       = hold_valid && shift_free;
  assign item.ready = !hold_valid || load;
  assign item_fire  = item.valid && item.ready;
  assign is_status  = item.func == FUNC_STATUS;
  assign emits      = !is_status || armed;
  assign over       = item.pending_count > drop_threshold;

  always_comb begin
    sel_flag  = 1'b0;
    sel_count = '0;
    for (int k = 0; k < NUM_SOURCES; k++) begin
      if (int'(item.source_id) == k) begin
        sel_flag  = drop_flag[k];
        sel_count = drop_count[k];
      end
    end
  end

  // Drop state as reported includes the update made by this item.
  always_comb begin
    rep_flag  = sel_flag;
    rep_count = sel_count;
    if (int'(item.source_id) < NUM_SOURCES && over) begin
      rep_flag  = 1'b1;
      rep_count = sel_count + 8'd1;
    end
  end

  assign pend_sat = (|item.pending_count[31:16]) ? PEND_MAX : item.pending_count[15:0];

  always_comb begin
    if (is_status) begin
      pkt = {pend_sat, item.timestamp_us, rep_count, 7'd0, rep_flag,
             7'd0, item.source_id, TYPE_STATUS, SYNC1, SYNC0};
    end else begin
      pkt = {32'd0, item.capture_word[23:16], item.capture_word[15:0],
             3'd0, ~item.capture_word[28:24], 7'd0, item.source_id,
             TYPE_EVENT, SYNC1, SYNC0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SOURCES; k++) begin
        drop_flag[k]  <= 1'b0;
        drop_count[k] <= '0;
      end
    end else if (item_fire && is_status && armed && over) begin
      for (int k = 0; k < NUM_SOURCES; k++) begin
        if (int'(item.source_id) == k) begin
          drop_flag[k]  <= 1'b1;
          drop_count[k] <= drop_count[k] + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_fire && emits) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && emits) begin
      hold_data <= pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_valid <= 1'b0;
      byte_idx    <= '0;
    end else if (load) begin
      shift_valid <= 1'b1;
      byte_idx    <= '0;
    end else if (out_fire) begin
      if (byte_idx == LAST_IDX) begin
        shift_valid <= 1'b0;
      end
      byte_idx <= byte_idx + BYTE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_data <= hold_data;
    end else if (out_fire) begin
      shift_data <= {8'd0, shift_data[PKT_W-1:8]};
    end
  end

  assign result.valid     = shift_valid;
  assign result.out_byte  = shift_data[7:0];
  assign result.last_byte = byte_idx == LAST_IDX;

endmodule

[src/bcpf_checker.sv]
// ----------------------------------------------------------------------------
// Bus capture packet framer checker
// Port-level properties of the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "bus_capture_packet_framer_top_assert.svh"

module bcpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);
  import bcpf_pkg::*;

  logic beat_done;
  assign beat_done = result_valid && result_ready;

  `BCPF_ASSERT_NEXT(a_reset_quiet, clk, rst, !result_valid && item_ready)
  `BCPF_ASSERT_RUN(a_stall_hold, clk, rst, result_valid && !result_ready,
    ##1 (result_valid && $stable(out_byte) && $stable(last_byte)))
  `BCPF_ASSERT_RUN(a_packet_contig, clk, rst, beat_done && !last_byte, ##1 result_valid)
  `BCPF_ASSERT_RUN(a_next_sync, clk, rst, beat_done && last_byte,
    ##1 (!result_valid || out_byte == SYNC0))

endmodule

bind bus_capture_packet_framer_top bcpf_checker u_bcpf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .out_byte     (result.out_byte),
  .last_byte    (result.last_byte)
);
